>>> hdl/cycling_speed_cadence_calc_defines.svh
// Assertion macros shared by the RTL.
`ifndef CYCLING_SPEED_CADENCE_CALC_DEFINES_SVH
`define CYCLING_SPEED_CADENCE_CALC_DEFINES_SVH
`ifndef ASSERT_OFF
`define CSC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSC_ASSERT(lbl, expr, msg)
`define CSC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/csc_pkg.sv
package csc_pkg;

  localparam int NUM_W = 60;
  localparam int DEN_W = 23;
  localparam int QUO_W = 16;

  localparam logic [11:0] CIRC_RESET = 12'd2200;
  localparam logic [11:0] CAD_MULT   = 12'd1500;  // 6144000 = 1500 << 12
  localparam logic [15:0] SAT16      = 16'hFFFF;

  localparam logic [3:0] IDX_MAX = 4'd15;

  typedef struct packed {
    logic        has_w;
    logic        has_c;
    logic [31:0] wcount;
    logic [15:0] wtime;
    logic [15:0] ccount;
    logic [15:0] ctime;
  } pkt_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> hdl/csc_front.sv
module csc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          q_full,
  output logic          full,
  output logic          q_wr,
  output csc_pkg::pkt_t q_data
);

  logic [3:0]  byte_index, byte_index_next;
  logic [1:0]  flags, flags_next;
  logic [31:0] wcount, wcount_next;
  logic [15:0] wtime, wtime_next;
  logic [15:0] ccount, ccount_next;
  logic [15:0] ctime, ctime_next;
  logic        accept;
  logic [3:0]  base;
  logic [3:0]  off_w, off_t, off_c, off_ct;
  logic [4:0]  need;
  logic [4:0]  got;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    byte_index_next = byte_index;
    flags_next      = flags;
    wcount_next     = wcount;
    wtime_next      = wtime;
    ccount_next     = ccount;
    ctime_next      = ctime;
    base            = flags[0] ? 4'd7 : 4'd1;
    off_w           = byte_index - 4'd1;
    off_t           = byte_index - 4'd5;
    off_c           = byte_index - base;
    off_ct          = byte_index - base - 4'd2;
    q_wr            = 1'b0;
    if (byte_index == 4'd0) begin
      flags_next = data_byte[1:0];
    end else if (flags[0] && byte_index <= 4'd4) begin
      wcount_next[8*off_w[1:0] +: 8] = data_byte;
    end else if (flags[0] && byte_index <= 4'd6) begin
      wtime_next[8*off_t[0] +: 8] = data_byte;
    end else if (flags[1] && byte_index >= base && byte_index <= base + 4'd1) begin
      ccount_next[8*off_c[0] +: 8] = data_byte;
    end else if (flags[1] && byte_index >= base + 4'd2 && byte_index <= base + 4'd3) begin
      ctime_next[8*off_ct[0] +: 8] = data_byte;
    end
    if (byte_index != csc_pkg::IDX_MAX) begin
      byte_index_next = byte_index + 4'd1;
    end
    need = 5'd1 + (flags_next[0] ? 5'd6 : 5'd0) + (flags_next[1] ? 5'd4 : 5'd0);
    got  = {1'b0, byte_index} + 5'd1;
    if (last_byte) begin
      byte_index_next = 4'd0;
      q_wr = accept && (got >= need);
    end
  end

  assign q_data.has_w  = flags_next[0];
  assign q_data.has_c  = flags_next[1];
  assign q_data.wcount = wcount_next;
  assign q_data.wtime  = wtime_next;
  assign q_data.ccount = ccount_next;
  assign q_data.ctime  = ctime_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 4'd0;
      flags      <= 2'd0;
    end else if (accept) begin
      byte_index <= byte_index_next;
      flags      <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wcount <= wcount_next;
      wtime  <= wtime_next;
      ccount <= ccount_next;
      ctime  <= ctime_next;
    end
  end

endmodule

>>> hdl/csc_fifo.sv
module csc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  csc_pkg::pkt_t wdata,
  input  logic          rd,
  output csc_pkg::pkt_t rdata,
  output logic          q_full,
  output logic          q_empty
);

  csc_pkg::pkt_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !q_full) begin
        wptr <= !wptr;
      end
      if (rd && !q_empty) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, wr && !q_full} - {1'b0, rd && !q_empty};
    end
  end

endmodule

>>> hdl/csc_div.sv
module csc_div (
  input  logic              clk,
  input  logic              rst,
  input  csc_pkg::div_req_t req,
  output csc_pkg::div_rsp_t rsp
);

  logic                      busy;
  logic                      done;
  logic [4:0]                cnt;
  logic [csc_pkg::DEN_W-1:0] den;
  logic [csc_pkg::DEN_W-1:0] rem;
  logic [15:0]               low;
  logic [15:0]               quot;
  logic [csc_pkg::DEN_W:0]   trial;
  logic                      ge;

  assign trial = {rem, low[15]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        den <= req.den;
        if (req.den == '0) begin
          quot <= 16'd0;
          done <= 1'b1;
        end else if (req.num[csc_pkg::NUM_W-1:16] >= {21'd0, req.den}) begin
          quot <= csc_pkg::SAT16;
          done <= 1'b1;
        end else begin
          // upper part is below den, so it fits the remainder
          rem  <= req.num[16 +: csc_pkg::DEN_W];
          low  <= req.num[15:0];
          cnt  <= 5'd16;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= ge ? trial[csc_pkg::DEN_W-1:0] - den : trial[csc_pkg::DEN_W-1:0];
        low  <= {low[14:0], 1'b0};
        quot <= {quot[14:0], ge};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

>>> hdl/csc_back.sv
module csc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [11:0]       circ,
  input  logic              q_empty,
  input  csc_pkg::pkt_t     q_data,
  output logic              q_rd,
  output csc_pkg::div_req_t dreq,
  input  csc_pkg::div_rsp_t drsp,
  input  logic              pop,
  output logic              empty,
  output logic              wheel_updated,
  output logic [15:0]       speed_centi_kmh,
  output logic [15:0]       wheel_cadence_centi_rpm,
  output logic [43:0]       ride_distance_mm,
  output logic              crank_updated,
  output logic [15:0]       crank_cadence_centi_rpm
);

  typedef enum logic [3:0] {
    S_IDLE, S_WCHK, S_WM1, S_WM2, S_WM3, S_WDIV1, S_WDIV2,
    S_CRK, S_CM, S_CS, S_CDIV, S_DONE
  } state_t;

  state_t        state;
  csc_pkg::pkt_t pkt;
  logic          wheel_seen, crank_seen;
  logic [31:0]   first_wc, prev_wc;
  logic [15:0]   prev_wt, prev_cc, prev_ct;
  logic [15:0]   held_speed, held_wcad, held_ccad;
  logic [43:0]   held_dist;
  logic [15:0]   dt;
  logic [31:0]   drev, dtot;
  logic          wu, cu;
  logic [31:0]   mul_a;
  logic [11:0]   mul_b;
  logic [43:0]   mul_p;
  logic          out_valid;
  logic [15:0]   ddc;

  assign ddc = pkt.ccount - prev_cc;

  always_comb begin
    mul_a = drev;
    mul_b = circ;
    case (state)
      S_WM1:   mul_a = dtot;
      // product stays drev*1500 while the speed division runs
      S_WM3, S_WDIV1: mul_b = csc_pkg::CAD_MULT;
      S_CM:    mul_b = csc_pkg::CAD_MULT;
      default: mul_b = circ;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state)
      S_WM3: begin
        // speed: drev*circ*36864 / (100*dt)
        dreq.start = 1'b1;
        dreq.num   = {1'b0, mul_p, 15'd0} + {4'd0, mul_p, 12'd0};
        dreq.den   = {1'b0, dt, 6'd0} + {2'd0, dt, 5'd0} + {5'd0, dt, 2'd0};
      end
      S_WDIV1, S_CS: begin
        dreq.start = (state == S_CS) || drsp.done;
        dreq.num   = {4'd0, mul_p, 12'd0};
        dreq.den   = {7'd0, dt};
      end
      default: dreq.start = 1'b0;
    endcase
  end

  assign q_rd  = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wheel_seen <= 1'b0;
      crank_seen <= 1'b0;
      held_speed <= 16'd0;
      held_wcad  <= 16'd0;
      held_ccad  <= 16'd0;
      held_dist  <= 44'd0;
      out_valid  <= 1'b0;
      wu         <= 1'b0;
      cu         <= 1'b0;
    end else begin
      mul_p <= mul_a * {32'd0, mul_b};
      if (pop && out_valid && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          wu <= 1'b0;
          cu <= 1'b0;
          if (!q_empty) begin
            pkt   <= q_data;
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (!pkt.has_w) begin
            state <= S_CRK;
          end else begin
            wheel_seen <= 1'b1;
            prev_wc    <= pkt.wcount;
            prev_wt    <= pkt.wtime;
            if (!wheel_seen) begin
              first_wc <= pkt.wcount;
              state    <= S_CRK;
            end else begin
              dt    <= pkt.wtime - prev_wt;
              drev  <= pkt.wcount - prev_wc;
              dtot  <= pkt.wcount - first_wc;
              state <= S_WM1;
            end
          end
        end
        S_WM1: state <= S_WM2;
        S_WM2: begin
          held_dist <= mul_p;
          state     <= S_WM3;
        end
        S_WM3: state <= S_WDIV1;
        S_WDIV1: begin
          if (drsp.done) begin
            held_speed <= drsp.quot;
            state      <= S_WDIV2;
          end
        end
        S_WDIV2: begin
          if (drsp.done) begin
            held_wcad <= drsp.quot;
            wu        <= 1'b1;
            state     <= S_CRK;
          end
        end
        S_CRK: begin
          if (!pkt.has_c || (crank_seen && prev_ct == pkt.ctime)) begin
            state <= S_DONE;
          end else begin
            crank_seen <= 1'b1;
            prev_cc    <= pkt.ccount;
            prev_ct    <= pkt.ctime;
            dt         <= pkt.ctime - prev_ct;
            drev       <= {16'd0, ddc};
            state      <= (crank_seen && ddc != 16'd0) ? S_CM : S_DONE;
          end
        end
        S_CM: state <= S_CS;
        S_CS: state <= S_CDIV;
        S_CDIV: begin
          if (drsp.done) begin
            held_ccad <= drsp.quot;
            cu        <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            out_valid               <= 1'b1;
            wheel_updated           <= wu;
            crank_updated           <= cu;
            speed_centi_kmh         <= held_speed;
            wheel_cadence_centi_rpm <= held_wcad;
            ride_distance_mm        <= held_dist;
            crank_cadence_centi_rpm <= held_ccad;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/cycling_speed_cadence_calc.sv
// Bytes are taken one per cycle into a two-packet queue; push stalls while it is full.
// Back end per packet: up to three divisions, run one at a time on the shared 16-step
// divider; a zero or saturating divide returns without running the steps.
// Synchronous active-high reset clears the control registers, not all data registers; circumference returns to 2200 mm.
`include "cycling_speed_cadence_calc_defines.svh"

module cycling_speed_cadence_calc (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic        wheel_updated,
  output logic [15:0] speed_centi_kmh,
  output logic [15:0] wheel_cadence_centi_rpm,
  output logic [43:0] ride_distance_mm,
  output logic        crank_updated,
  output logic [15:0] crank_cadence_centi_rpm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  logic              q_wr, q_rd, q_full, q_empty;
  csc_pkg::pkt_t     q_wdata, q_rdata;
  csc_pkg::div_req_t dreq;
  csc_pkg::div_rsp_t drsp;
  logic [11:0]       circ;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      circ <= csc_pkg::CIRC_RESET;
    end else if (cfg_valid) begin
      circ <= cfg_data;
    end
  end

  csc_front u_front (
    .clk(clk), .rst(rst), .push(push), .data_byte(data_byte), .last_byte(last_byte),
    .q_full(q_full), .full(full), .q_wr(q_wr), .q_data(q_wdata)
  );

  csc_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(q_wr), .wdata(q_wdata), .rd(q_rd), .rdata(q_rdata),
    .q_full(q_full), .q_empty(q_empty)
  );

  csc_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .rsp(drsp)
  );

  csc_back u_back (
    .clk(clk), .rst(rst), .circ(circ), .q_empty(q_empty), .q_data(q_rdata),
    .q_rd(q_rd), .dreq(dreq), .drsp(drsp), .pop(pop), .empty(empty),
    .wheel_updated(wheel_updated), .speed_centi_kmh(speed_centi_kmh),
    .wheel_cadence_centi_rpm(wheel_cadence_centi_rpm),
    .ride_distance_mm(ride_distance_mm), .crank_updated(crank_updated),
    .crank_cadence_centi_rpm(crank_cadence_centi_rpm)
  );

  `CSC_ASSERT(a_q_no_overflow, !(q_wr && q_full), "packet queue overflow")
  `CSC_ASSERT(a_q_no_underflow, !(q_rd && q_empty), "packet queue underflow")
  `CSC_ASSERT_IMP(a_result_held, !empty && !pop, !empty, "waiting result dropped")

endmodule
